### src/swi_pkg.sv
// Package for the sorted word table: shared types, codes and the byte mask helper.
`timescale 1ns / 1ps

package swi_pkg;

	localparam int POS_W = 10;
	localparam int CNT_W = 11;
	localparam int IDX_W = 10;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_CHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_READ_RD,
		S_READ_DATA,
		S_DONE
	} seq_state_t;

	// Packed big-endian, so unsigned order of the whole struct is string order.
	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [55:0] d;
	} word_t;

	typedef struct packed {
		cmd_t             command;
		word_t            word;
		logic [IDX_W-1:0] read_index;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] entry_count;
		word_t            data;
	} result_t;

	typedef struct packed {
		logic start;
		logic done_ack;
		logic sort_en;
	} seq_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

	// Keeps the bytes of a part (first byte number base, n bytes) below wb.
	function automatic logic [63:0] part_mask(int base, int n, int wb);
		int k;
		logic [63:0] m;
		k = wb - base;
		m = '0;
		if (k >= n) begin
			m = (n == 8) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h00FF_FFFF_FFFF_FFFF;
		end else if (k > 0) begin
			m = ((64'd1 << (8 * k)) - 64'd1) << (8 * (n - k));
		end
		return m;
	endfunction

endpackage

### src/swi_if.sv
// Handshake channel interfaces for the sorted word table.
`timescale 1ns / 1ps

interface swi_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [63:0] word_bytes_0_7;
	logic [63:0] word_bytes_8_15;
	logic [63:0] word_bytes_16_23;
	logic [55:0] word_bytes_24_30;
	logic [9:0]  read_index;

	modport source (output valid, command, word_bytes_0_7, word_bytes_8_15,
		word_bytes_16_23, word_bytes_24_30, read_index, input ready);
	modport sink (input valid, command, word_bytes_0_7, word_bytes_8_15,
		word_bytes_16_23, word_bytes_24_30, read_index, output ready);
endinterface

interface swi_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [9:0]  position;
	logic [10:0] entry_count;
	logic [63:0] out_bytes_0_7;
	logic [63:0] out_bytes_8_15;
	logic [63:0] out_bytes_16_23;
	logic [55:0] out_bytes_24_30;

	modport source (output valid, status, position, entry_count, out_bytes_0_7,
		out_bytes_8_15, out_bytes_16_23, out_bytes_24_30, input ready);
	modport sink (input valid, status, position, entry_count, out_bytes_0_7,
		out_bytes_8_15, out_bytes_16_23, out_bytes_24_30, output ready);
endinterface

interface swi_cfg_if;
	logic valid;
	logic ready;
	logic sort_enable;

	modport source (output valid, sort_enable, input ready);
	modport sink (input valid, sort_enable, output ready);
endinterface

### src/sorted_word_insert_table.sv
// Sorted word table top level: channels, sort_enable register and result register.
// An insert with sorting on scans the entries from the bottom to find its slot, moves the
// entries from the slot up by one and then writes the word; a valid read reads the memory
// once, and an insert into a full table and other commands go straight to the result.
// Throughput: one item at a time; the scan and the shift share the one memory read port,
// with a read state and a compare or write state per entry. A new item is taken while
// the last result waits. Reset clears the entry count and sets sort_enable to one; the
// word memory is not cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps

module sorted_word_insert_table #(
	parameter int CAPACITY   = 1024,
	parameter int WORD_BYTES = 31
) (
	input logic          clk,
	input logic          arst_n,
	swi_req_if.sink      req,
	swi_rsp_if.source    rsp,
	swi_cfg_if.sink      cfg
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [63:0] MASK_A = swi_pkg::part_mask(0, 8, WORD_BYTES);
	localparam logic [63:0] MASK_B = swi_pkg::part_mask(8, 8, WORD_BYTES);
	localparam logic [63:0] MASK_C = swi_pkg::part_mask(16, 8, WORD_BYTES);
	localparam logic [55:0] MASK_D = 56'(swi_pkg::part_mask(24, 7, WORD_BYTES));

	logic               sort_en_q;
	logic               out_valid_q;
	swi_pkg::result_t   out_res_q;
	swi_pkg::result_t   res;
	swi_pkg::req_t      req_item;
	swi_pkg::seq_ctl_t  ctl;
	swi_pkg::seq_stat_t stat;
	logic               load;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [AW-1:0]      mem_raddr;
	swi_pkg::word_t     mem_wdata;
	swi_pkg::word_t     mem_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_en_q <= 1'b1;
		end else if (cfg.valid) begin
			sort_en_q <= cfg.sort_enable;
		end
	end

	// Bytes past the word length are forced to zero before they are stored.
	assign req_item.command    = swi_pkg::cmd_t'(req.command);
	assign req_item.word.a     = req.word_bytes_0_7 & MASK_A;
	assign req_item.word.b     = req.word_bytes_8_15 & MASK_B;
	assign req_item.word.c     = req.word_bytes_16_23 & MASK_C;
	assign req_item.word.d     = req.word_bytes_24_30 & MASK_D;
	assign req_item.read_index = req.read_index;

	assign req.ready    = stat.idle;
	assign load         = stat.done && (!out_valid_q || rsp.ready);
	assign ctl.start    = req.valid && stat.idle;
	assign ctl.done_ack = load;
	assign ctl.sort_en  = sort_en_q;

	swi_seq #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.req       (req_item),
		.stat      (stat),
		.res_q     (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	swi_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q <= res;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_res_q.status;
	assign rsp.position        = out_res_q.position;
	assign rsp.entry_count     = out_res_q.entry_count;
	assign rsp.out_bytes_0_7   = out_res_q.data.a;
	assign rsp.out_bytes_8_15  = out_res_q.data.b;
	assign rsp.out_bytes_16_23 = out_res_q.data.c;
	assign rsp.out_bytes_24_30 = out_res_q.data.d;

endmodule

### src/swi_mem.sv
// Word storage: one write port and one registered read port.
`timescale 1ns / 1ps

module swi_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  swi_pkg::word_t wdata,
	input  logic [AW-1:0]  raddr,
	output swi_pkg::word_t rdata_q
);

	swi_pkg::word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

endmodule

### src/swi_seq.sv
// Command sequencer: scan with the shared word comparator, shift, write and read.
`timescale 1ns / 1ps

module swi_seq #(
	parameter int CAPACITY = 1024,
	parameter int AW       = 10,
	parameter int CW       = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  swi_pkg::seq_ctl_t  ctl,
	input  swi_pkg::req_t      req,
	output swi_pkg::seq_stat_t stat,
	output swi_pkg::result_t   res_q,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output swi_pkg::word_t     mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  swi_pkg::word_t     mem_rdata
);

	localparam int XW = (CW > swi_pkg::IDX_W) ? CW : swi_pkg::IDX_W;

	swi_pkg::seq_state_t state_q, state_d;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       slot_q;
	logic [AW-1:0]       j_q;
	swi_pkg::word_t      word_q;

	logic [AW-1:0] slot_inc;
	logic [AW-1:0] j_dec;
	logic [CW-1:0] count_inc;
	logic [XW-1:0] idx_x;
	logic          word_gt;
	logic          full;
	logic          bad_index;

	assign slot_inc  = slot_q + 1'b1;
	assign j_dec     = j_q - 1'b1;
	assign count_inc = count_q + 1'b1;
	assign idx_x     = XW'(req.read_index);
	assign full      = (count_q == CW'(CAPACITY));
	assign bad_index = (idx_x >= XW'(count_q));
	// The one wide comparator, reused for every entry of the scan.
	assign word_gt   = (word_q > mem_rdata);

	assign stat.idle = (state_q == swi_pkg::S_IDLE);
	assign stat.done = (state_q == swi_pkg::S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swi_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == swi_pkg::S_PUT) begin
				count_q <= count_inc;
			end else if (stat.idle && ctl.start && req.command == swi_pkg::CMD_CLEAR) begin
				count_q <= '0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = word_q;
		mem_raddr = slot_q;
		unique case (state_q)
			swi_pkg::S_IDLE: begin
				if (ctl.start) begin
					case (req.command)
						swi_pkg::CMD_INSERT: begin
							if (full) begin
								state_d = swi_pkg::S_DONE;
							end else if (ctl.sort_en && count_q != '0) begin
								state_d = swi_pkg::S_SCAN_RD;
							end else begin
								state_d = swi_pkg::S_SHIFT_CHK;
							end
						end
						swi_pkg::CMD_READ: begin
							state_d = bad_index ? swi_pkg::S_DONE : swi_pkg::S_READ_RD;
						end
						default: begin
							state_d = swi_pkg::S_DONE;
						end
					endcase
				end
			end
			swi_pkg::S_SCAN_RD: begin
				state_d = swi_pkg::S_SCAN_CMP;
			end
			swi_pkg::S_SCAN_CMP: begin
				if (word_gt && CW'(slot_inc) < count_q) begin
					state_d = swi_pkg::S_SCAN_RD;
				end else begin
					state_d = swi_pkg::S_SHIFT_CHK;
				end
			end
			swi_pkg::S_SHIFT_CHK: begin
				state_d = (j_q > slot_q) ? swi_pkg::S_SHIFT_RD : swi_pkg::S_PUT;
			end
			swi_pkg::S_SHIFT_RD: begin
				mem_raddr = j_dec;
				state_d   = swi_pkg::S_SHIFT_WR;
			end
			swi_pkg::S_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = mem_rdata;
				state_d   = (j_dec > slot_q) ? swi_pkg::S_SHIFT_RD : swi_pkg::S_PUT;
			end
			swi_pkg::S_PUT: begin
				mem_we  = 1'b1;
				state_d = swi_pkg::S_DONE;
			end
			swi_pkg::S_READ_RD: begin
				state_d = swi_pkg::S_READ_DATA;
			end
			swi_pkg::S_READ_DATA: begin
				state_d = swi_pkg::S_DONE;
			end
			swi_pkg::S_DONE: begin
				if (ctl.done_ack) begin
					state_d = swi_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = swi_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			swi_pkg::S_IDLE: begin
				if (ctl.start) begin
					word_q     <= req.word;
					j_q        <= AW'(count_q);
					res_q.data <= '0;
					case (req.command)
						swi_pkg::CMD_INSERT: begin
							res_q.status      <= full ? swi_pkg::ST_FULL : swi_pkg::ST_OK;
							res_q.position    <= '0;
							res_q.entry_count <= swi_pkg::CNT_W'(count_q);
							slot_q            <= ctl.sort_en ? '0 : AW'(count_q);
						end
						swi_pkg::CMD_READ: begin
							res_q.status      <= bad_index ? swi_pkg::ST_BAD_INDEX
								: swi_pkg::ST_OK;
							res_q.position    <= req.read_index;
							res_q.entry_count <= swi_pkg::CNT_W'(count_q);
							slot_q            <= idx_x[AW-1:0];
						end
						swi_pkg::CMD_CLEAR: begin
							res_q.status      <= swi_pkg::ST_OK;
							res_q.position    <= '0;
							res_q.entry_count <= '0;
							slot_q            <= '0;
						end
						default: begin
							res_q.status      <= swi_pkg::ST_OK;
							res_q.position    <= '0;
							res_q.entry_count <= swi_pkg::CNT_W'(count_q);
							slot_q            <= '0;
						end
					endcase
				end
			end
			swi_pkg::S_SCAN_CMP: begin
				if (word_gt) begin
					slot_q <= slot_inc;
				end
			end
			swi_pkg::S_SHIFT_WR: begin
				j_q <= j_dec;
			end
			swi_pkg::S_PUT: begin
				res_q.position    <= swi_pkg::POS_W'(slot_q);
				res_q.entry_count <= swi_pkg::CNT_W'(count_inc);
			end
			swi_pkg::S_READ_DATA: begin
				res_q.data <= mem_rdata;
			end
			default: begin
			end
		endcase
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == swi_pkg::S_IDLE)
		else $error("item started while busy");

	a_ack_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done_ack |-> state_q == swi_pkg::S_DONE)
		else $error("result taken with none ready");

	a_shift_above_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swi_pkg::S_SHIFT_WR |-> j_q > slot_q)
		else $error("shift wrote at or below the insert slot");

	a_put_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swi_pkg::S_PUT |=> count_q == $past(count_inc))
		else $error("insert did not advance the count");

endmodule

### dv/swi_table_checker.sv
// Checker for the sorted word table: watches the channels, predicts each result and compares it.
`timescale 1ns / 1ps

module swi_table_checker #(
	parameter int CAPACITY   = 1024,
	parameter int WORD_BYTES = 31
) (
	input  logic clk,
	input  logic arst_n,
	swi_req_if   req,
	swi_rsp_if   rsp,
	swi_cfg_if   cfg,
	output int   mismatches,
	output int   pending_items
);

	swi_pkg::word_t   table_words [CAPACITY];
	int               held;
	bit               sort_on;
	swi_pkg::result_t expected_results [$];
	int               result_no;

	task automatic report_mismatch(string what);
		$display("%0t ns: MISMATCH %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d field %s is %h, expected %h",
				result_no, name, got, want));
		end
	endtask

	// Bytes at or past the word length are dropped before the word is stored.
	function automatic swi_pkg::word_t kept_bytes(swi_pkg::word_t w);
		logic [247:0] m;
		m = '0;
		for (int i = 0; i < 31; i++) begin
			if (i < WORD_BYTES) begin
				m[247 - 8 * i -: 8] = 8'hFF;
			end
		end
		return w & m;
	endfunction

	function automatic swi_pkg::result_t apply_command(logic [1:0] command,
		swi_pkg::word_t w, logic [9:0] idx);
		swi_pkg::result_t r;
		swi_pkg::word_t   nw;
		int               slot;
		r = '0;
		case (command)
			swi_pkg::CMD_INSERT: begin
				nw = kept_bytes(w);
				if (held >= CAPACITY) begin
					r.status = swi_pkg::ST_FULL;
				end else begin
					slot = held;
					if (sort_on) begin
						// First entry not below the new word; equal words go in front.
						slot = 0;
						while (slot < held && nw > table_words[slot]) begin
							slot++;
						end
					end
					for (int j = held; j > slot; j--) begin
						table_words[j] = table_words[j - 1];
					end
					table_words[slot] = nw;
					held++;
					r.position = swi_pkg::POS_W'(slot);
				end
			end
			swi_pkg::CMD_READ: begin
				r.position = idx;
				if (idx >= held || idx >= CAPACITY) begin
					r.status = swi_pkg::ST_BAD_INDEX;
				end else begin
					r.data = table_words[idx];
				end
			end
			swi_pkg::CMD_CLEAR: begin
				held = 0;
			end
			default: begin
			end
		endcase
		r.entry_count = swi_pkg::CNT_W'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		swi_pkg::result_t want;
		if (!arst_n) begin
			held = 0;
			sort_on = 1'b1;
			result_no = 0;
			mismatches = 0;
			expected_results.delete();
			pending_items <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				sort_on = cfg.sort_enable;
			end
			if (req.valid && req.ready) begin
				expected_results.push_back(apply_command(req.command,
					{req.word_bytes_0_7, req.word_bytes_8_15, req.word_bytes_16_23,
					req.word_bytes_24_30}, req.read_index));
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no item waiting",
						result_no));
				end else begin
					want = expected_results.pop_front();
					check_field("status", 64'(rsp.status), 64'(want.status));
					check_field("position", 64'(rsp.position), 64'(want.position));
					check_field("entry_count", 64'(rsp.entry_count),
						64'(want.entry_count));
					check_field("out_bytes_0_7", rsp.out_bytes_0_7, want.data.a);
					check_field("out_bytes_8_15", rsp.out_bytes_8_15, want.data.b);
					check_field("out_bytes_16_23", rsp.out_bytes_16_23, want.data.c);
					check_field("out_bytes_24_30", 64'(rsp.out_bytes_24_30),
						64'(want.data.d));
				end
				result_no++;
			end
			pending_items <= expected_results.size();
		end
	end

endmodule

### dv/tb_sorted_word_insert_table.sv
// Testbench top for the sorted word table: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_sorted_word_insert_table;

	localparam int          TABLE_CAP   = 1024;
	localparam int          WORD_LEN    = 31;
	localparam logic [1:0]  CMD_UNUSED  = 2'd3;
	localparam int          DRAIN_WAIT  = 20;
	localparam int          HOLD_CYCLES = 300;
	localparam int          APPEND_RUN  = 20;
	localparam int          PHASE_ITEMS = 56;
	// About 290 items; even at a full-length scan plus long stalls on every one
	// the run stays far below this.
	localparam longint      CYCLE_LIMIT = 2_000_000;

	logic           clk = 1'b0;
	logic           arst_n;
	bit             hold_off;
	int             send_idle_pct;
	int             recv_stall_pct;
	int             held_guess;
	int             mismatches;
	int             pending_items;
	longint         cycle_count = 0;
	swi_pkg::word_t recent_words [$];
	int             send_idle_by_phase [4] = '{0, 87, 0, 22};
	int             recv_stall_by_phase [4] = '{0, 0, 87, 22};

	swi_req_if req_ch ();
	swi_rsp_if rsp_ch ();
	swi_cfg_if cfg_ch ();

	sorted_word_insert_table #(
		.CAPACITY  (TABLE_CAP),
		.WORD_BYTES(WORD_LEN)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	swi_table_checker #(
		.CAPACITY  (TABLE_CAP),
		.WORD_BYTES(WORD_LEN)
	) table_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.cfg          (cfg_ch),
		.mismatches   (mismatches),
		.pending_items(pending_items)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic swi_pkg::word_t noise_word();
		logic [255:0] v;
		v = {$urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom()};
		return v[247:0];
	endfunction

	function automatic swi_pkg::word_t text_word(string s);
		logic [247:0] v;
		v = '0;
		for (int i = 0; i < s.len() && i < 31; i++) begin
			v[247 - 8 * i -: 8] = s[i];
		end
		return v;
	endfunction

	function automatic swi_pkg::word_t fill_word(int len, logic [7:0] b);
		logic [247:0] v;
		v = '0;
		for (int i = 0; i < len; i++) begin
			v[247 - 8 * i -: 8] = b;
		end
		return v;
	endfunction

	// Mostly short words over a three letter alphabet, so that prefixes are shared
	// and duplicates are common; the rest are long words, repeats and raw bits.
	function automatic swi_pkg::word_t make_word();
		int           kind;
		int           len;
		logic [247:0] v;
		kind = $urandom_range(19);
		v = '0;
		if (kind < 12) begin
			len = $urandom_range(6);
			for (int i = 0; i < len; i++) begin
				v[247 - 8 * i -: 8] = 8'(8'h61 + $urandom_range(2));
			end
		end else if (kind < 15) begin
			len = $urandom_range(31);
			for (int i = 0; i < len; i++) begin
				v[247 - 8 * i -: 8] = 8'($urandom_range(255, 1));
			end
		end else if (kind < 17 && recent_words.size() > 0) begin
			v = recent_words[$urandom_range(recent_words.size() - 1)];
		end else if (kind < 19) begin
			v = noise_word();
		end else begin
			v = $urandom_range(1) ? '1 : '0;
		end
		return v;
	endfunction

	task automatic send_item(logic [1:0] command, swi_pkg::word_t w, logic [9:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid            <= 1'b1;
		req_ch.command          <= command;
		req_ch.word_bytes_0_7   <= w.a;
		req_ch.word_bytes_8_15  <= w.b;
		req_ch.word_bytes_16_23 <= w.c;
		req_ch.word_bytes_24_30 <= w.d;
		req_ch.read_index       <= idx;
		do @(posedge clk); while (!req_ch.ready);
		case (command)
			swi_pkg::CMD_INSERT: begin
				if (held_guess < TABLE_CAP) begin
					held_guess++;
				end
			end
			swi_pkg::CMD_CLEAR: begin
				held_guess = 0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic insert_word(swi_pkg::word_t w);
		send_item(swi_pkg::CMD_INSERT, w, 10'($urandom_range(1023)));
	endtask

	task automatic read_entry(logic [9:0] idx);
		send_item(swi_pkg::CMD_READ, noise_word(), idx);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_items != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_sort(bit en);
		wait_idle();
		cfg_ch.valid       <= 1'b1;
		cfg_ch.sort_enable <= en;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_item();
		int             pick;
		swi_pkg::word_t w;
		logic [9:0]     idx;
		pick = $urandom_range(99);
		w = noise_word();
		idx = 10'($urandom_range(1023));
		if (held_guess >= 48) begin
			send_item(swi_pkg::CMD_CLEAR, w, idx);
		end else if (pick < 55) begin
			w = make_word();
			if (recent_words.size() >= 16) begin
				void'(recent_words.pop_front());
			end
			recent_words.push_back(w);
			send_item(swi_pkg::CMD_INSERT, w, idx);
		end else if (pick < 82) begin
			if (held_guess > 0) begin
				idx = 10'($urandom_range(held_guess - 1));
			end
			send_item(swi_pkg::CMD_READ, w, idx);
		end else if (pick < 90) begin
			if ($urandom_range(1)) begin
				idx = 10'(held_guess);
			end
			send_item(swi_pkg::CMD_READ, w, idx);
		end else if (pick < 96) begin
			send_item(swi_pkg::CMD_CLEAR, w, idx);
		end else begin
			send_item(CMD_UNUSED, w, idx);
		end
	endtask

	initial begin
		swi_pkg::word_t odd_word;
		arst_n                  = 1'b0;
		hold_off                = 1'b0;
		send_idle_pct           = 0;
		recv_stall_pct          = 0;
		held_guess              = 0;
		req_ch.valid            = 1'b0;
		req_ch.command          = swi_pkg::CMD_INSERT;
		req_ch.word_bytes_0_7   = '0;
		req_ch.word_bytes_8_15  = '0;
		req_ch.word_bytes_16_23 = '0;
		req_ch.word_bytes_24_30 = '0;
		req_ch.read_index       = '0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.sort_enable      = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sorted inserts from reset, including an equal word, the empty word, the
		// largest word and a word with bytes after its terminator.
		read_entry(0);
		insert_word(text_word("abc"));
		insert_word(text_word("abd"));
		insert_word(text_word("abc"));
		insert_word(text_word("ab"));
		insert_word('0);
		insert_word(fill_word(31, 8'hFF));
		insert_word(fill_word(31, "z"));
		odd_word = text_word("ab");
		odd_word[247 - 24 -: 8] = "z";
		insert_word(odd_word);
		insert_word(text_word("b"));
		send_item(CMD_UNUSED, noise_word(), 10'h3FF);
		for (int i = 0; i <= 9; i++) begin
			read_entry(10'(i));
		end
		read_entry(10'h3FF);
		send_item(swi_pkg::CMD_CLEAR, noise_word(), 10'h3FF);
		read_entry(0);

		// A short run in arrival order, then one sorted insert into the unsorted
		// table, read back around the end of the held entries.
		set_sort(1'b0);
		for (int i = 0; i < APPEND_RUN; i++) begin
			insert_word(make_word());
		end
		read_entry(0);
		read_entry(10'(APPEND_RUN - 1));
		read_entry(10'(APPEND_RUN));
		set_sort(1'b1);
		insert_word(text_word("m"));
		read_entry(10'(APPEND_RUN));
		send_item(swi_pkg::CMD_CLEAR, noise_word(), 10'h0);
		read_entry(10'h3FF);

		for (int p = 0; p < 4; p++) begin
			set_sort(p % 2 == 0);
			send_idle_pct = send_idle_by_phase[p];
			recv_stall_pct = recv_stall_by_phase[p];
			if (p == 0) begin
				// The result side stops taking items for a while so that the
				// block backs up and holds off its input.
				fork
					begin
						hold_off <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_off <= 1'b0;
					end
					begin
						repeat (12) random_item();
					end
				join
			end
			repeat (PHASE_ITEMS) random_item();
		end

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
